// ===== design/kuwahara_filter_assert.svh =====
// assertion macros used by the kuwahara_filter design file
`ifndef KUWAHARA_FILTER_ASSERT_SVH
`define KUWAHARA_FILTER_ASSERT_SVH

// condition holds at every edge outside reset
`define KUW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define KUW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kuw_pkg.sv =====
package kuw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int WINDOW_W   = 4;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int NUM_QUAD   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } cell_ctrl_t;

endpackage

// ===== design/kuw_ram.sv =====
module kuw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15360
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kuw_cell.sv =====
module kuw_cell #(
  parameter int Q          = 0,
  parameter int PIXEL_BITS = 8,
  parameter int WK         = 4,
  parameter int CW         = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kuw_pkg::cell_ctrl_t         ctrl,
  input  logic [WK-1:0]               hw,
  input  logic [CW-1:0]               cnt,
  input  logic                        in_valid,
  input  logic [WK-1:0]               in_dy,
  input  logic [WK-1:0]               in_dx,
  input  logic [PIXEL_BITS-1:0]       in_pix,
  output logic                        out_valid,
  output logic [WK-1:0]               out_dy,
  output logic [WK-1:0]               out_dx,
  output logic [PIXEL_BITS-1:0]       out_pix,
  output logic [PIXEL_BITS+CW-1:0]    sum,
  output logic [2*PIXEL_BITS+2*CW-1:0] quad_var
);
  import kuw_pkg::*;

  localparam int SW = PIXEL_BITS + CW;
  localparam int QW = 2 * PIXEL_BITS + CW;
  localparam int VW = 2 * PIXEL_BITS + 2 * CW;
  localparam logic BOTTOM = 1'((Q >> 1) & 1);
  localparam logic RIGHT  = 1'(Q & 1);

  logic [QW-1:0] sumsq;
  logic [VW-1:0] prod_a;
  logic [VW-1:0] prod_b;
  logic          row_in;
  logic          col_in;

  assign row_in = BOTTOM ? (in_dy >= hw) : (in_dy <= hw);
  assign col_in = RIGHT  ? (in_dx >= hw) : (in_dx <= hw);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_dy  <= in_dy;
    out_dx  <= in_dx;
    out_pix <= in_pix;
    if (ctrl.clear) begin
      sum   <= '0;
      sumsq <= '0;
    end else if (in_valid && row_in && col_in) begin
      sum   <= sum + SW'(in_pix);
      sumsq <= sumsq + QW'(in_pix) * QW'(in_pix);
    end
    if (ctrl.mul_en) begin
      prod_a <= VW'(cnt) * VW'(sumsq);
      prod_b <= VW'(sum) * VW'(sum);
    end
  end

  assign quad_var = prod_a - prod_b;

endmodule

// ===== design/kuwahara_filter.sv =====
// Grayscale Kuwahara filter on a raster pixel stream. Pixels are written into
// a line store of MAX_WINDOW rows by MAX_WIDTH columns; with an odd window k
// each interior output is computed when the bottom-right pixel of its window
// arrives. That pixel then reads its k*k window on the single line-store
// read port, which feeds a chain of four quadrant cells; the chain drains,
// then come one multiply, four compares, one divide step per output bit and
// the output register. No new pixel is accepted meanwhile. Pixels that make
// no output leave the block idle for the next pixel, and an even window
// passes each pixel straight through the output register. Any register
// write restarts the frame at row 0, column 0. Outputs carry their row and
// column; frame_last marks the result of the frame's final input pixel.
`include "kuwahara_filter_assert.svh"

module kuwahara_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  parameter int PIXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kuw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kuw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PIXEL_BITS-1:0]           pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kuw_pkg::ROW_W-1:0]       out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]    out_col,
  output logic [PIXEL_BITS-1:0]           pixel_out,
  output logic                            frame_last
);
  import kuw_pkg::*;

  localparam int CLW      = $clog2(MAX_WIDTH);
  localparam int WK       = $clog2(MAX_WINDOW + 1);
  localparam int SIDE_MAX = MAX_WINDOW / 2 + 1;
  localparam int CW       = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int SW       = PIXEL_BITS + CW;
  localparam int VW       = 2 * PIXEL_BITS + 2 * CW;
  localparam int NW       = PIXEL_BITS + 1 + CW;
  localparam int DEPTH    = MAX_WINDOW * MAX_WIDTH;
  localparam int AW       = $clog2(DEPTH);
  localparam int BW       = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WINDOW_W-1:0] window_size;

  logic [CLW:0]        eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [WK-1:0]       eff_k;
  logic [WK-1:0]       hw;
  logic [WK-1:0]       twoh;
  logic                pass;

  logic [ROW_W-1:0]    row_cnt;
  logic [CLW-1:0]      col_cnt;
  logic [WK-1:0]       row_slot;

  state_t              state;
  logic                xfer;
  logic                interior;
  logic                last;
  logic                row_end;
  logic                res_load;

  logic [WK-1:0]       rd_slot;
  logic [WK-1:0]       rd_dy;
  logic [WK-1:0]       rd_dx;
  logic [CLW-1:0]      col_base;
  logic [2:0]          drain_cnt;
  logic [1:0]          qd;
  logic [BW-1:0]       bit_idx;
  logic [CW-1:0]       cnt;

  logic [ROW_W-1:0]    res_row;
  logic [CLW-1:0]      res_col;
  logic                res_last;

  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [PIXEL_BITS-1:0] rdata;
  logic                tag_valid;
  logic [WK-1:0]       tag_dy;
  logic [WK-1:0]       tag_dx;

  cell_ctrl_t          ctrl;
  logic                ch_valid [NUM_QUAD+1];
  logic [WK-1:0]       ch_dy    [NUM_QUAD+1];
  logic [WK-1:0]       ch_dx    [NUM_QUAD+1];
  logic [PIXEL_BITS-1:0] ch_pix [NUM_QUAD+1];
  logic [SW-1:0]       q_sum    [NUM_QUAD];
  logic [VW-1:0]       q_var    [NUM_QUAD];

  logic [SW-1:0]       best_sum;
  logic [VW-1:0]       best_var;
  logic                take;
  logic [SW-1:0]       sel_sum;
  logic [NW-1:0]       rem;
  logic [NW-1:0]       den_sh;
  logic [PIXEL_BITS-1:0] quo;

  assign eff_w = (image_width == '0) ? (CLW+1)'(1) :
                 (32'(image_width) > MAX_WIDTH) ? (CLW+1)'(MAX_WIDTH) :
                 (CLW+1)'(image_width);
  assign eff_h = (image_height == '0) ? HEIGHT_W'(1) :
                 (32'(image_height) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) :
                 image_height;
  assign eff_k = (32'(window_size) > MAX_WINDOW) ? WK'(MAX_WINDOW) : WK'(window_size);
  assign hw    = eff_k >> 1;
  assign twoh  = eff_k - WK'(1);
  assign pass  = ~eff_k[0];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready || !pass);
  assign xfer     = in_valid && in_ready;
  assign interior = (32'(row_cnt) >= 32'(twoh)) && (32'(col_cnt) >= 32'(twoh));
  assign last     = (32'(row_cnt) == 32'(eff_h) - 1) && (32'(col_cnt) == 32'(eff_w) - 1);
  assign row_end  = (32'(col_cnt) + 1 >= 32'(eff_w));
  assign res_load = (xfer && pass) || (state == S_OUT && (!out_valid || out_ready));

  assign waddr = AW'(row_slot) * AW'(MAX_WIDTH) + AW'(col_cnt);
  assign raddr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(col_base) + AW'(rd_dx);

  kuw_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (xfer && !pass),
    .waddr(waddr),
    .wdata(pixel_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ctrl.clear  = xfer;
  assign ctrl.mul_en = (state == S_MUL);

  assign ch_valid[0] = tag_valid;
  assign ch_dy[0]    = tag_dy;
  assign ch_dx[0]    = tag_dx;
  assign ch_pix[0]   = rdata;

  for (genvar g = 0; g < NUM_QUAD; g++) begin : g_cell
    kuw_cell #(
      .Q         (g),
      .PIXEL_BITS(PIXEL_BITS),
      .WK        (WK),
      .CW        (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .hw       (hw),
      .cnt      (cnt),
      .in_valid (ch_valid[g]),
      .in_dy    (ch_dy[g]),
      .in_dx    (ch_dx[g]),
      .in_pix   (ch_pix[g]),
      .out_valid(ch_valid[g+1]),
      .out_dy   (ch_dy[g+1]),
      .out_dx   (ch_dx[g+1]),
      .out_pix  (ch_pix[g+1]),
      .sum      (q_sum[g]),
      .quad_var (q_var[g])
    );
  end

  assign take    = (qd == 2'd0) || (q_var[qd] < best_var);
  assign sel_sum = take ? q_sum[qd] : best_sum;
  assign den_sh  = NW'({cnt, 1'b0}) << bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(640);
      image_height <= HEIGHT_W'(480);
      window_size  <= WINDOW_W'(5);
      row_cnt      <= '0;
      col_cnt      <= '0;
      row_slot     <= '0;
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      tag_valid    <= 1'b0;
    end else begin
      tag_valid <= (state == S_READ);
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  image_width  <= WIDTH_W'(cfg_data);
          CFG_HEIGHT: image_height <= cfg_data;
          CFG_WINDOW: window_size  <= WINDOW_W'(cfg_data);
          default: ;
        endcase
        if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
            cfg_index == CFG_WINDOW) begin
          row_cnt  <= '0;
          col_cnt  <= '0;
          row_slot <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (xfer) begin
            if (row_end) begin
              col_cnt <= '0;
              if (32'(row_cnt) + 1 >= 32'(eff_h)) begin
                row_cnt  <= '0;
                row_slot <= '0;
              end else begin
                row_cnt  <= row_cnt + ROW_W'(1);
                row_slot <= (row_slot == twoh) ? '0 : row_slot + WK'(1);
              end
            end else begin
              col_cnt <= col_cnt + CLW'(1);
            end
            if (pass) begin
              out_valid <= 1'b1;
            end else if (interior) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_dx == twoh) begin
            if (rd_dy == twoh) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (drain_cnt == 3'(NUM_QUAD)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (qd == 2'(NUM_QUAD - 1)) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_idx == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tag_dy <= rd_dy;
    tag_dx <= rd_dx;
    case (state)
      S_IDLE: begin
        if (xfer) begin
          rd_slot   <= (row_slot == twoh) ? '0 : row_slot + WK'(1);
          rd_dy     <= '0;
          rd_dx     <= '0;
          col_base  <= col_cnt - CLW'(twoh);
          cnt       <= CW'((32'(hw) + 1) * (32'(hw) + 1));
          res_row   <= row_cnt - ROW_W'(hw);
          res_col   <= col_cnt - CLW'(hw);
          res_last  <= last;
          drain_cnt <= '0;
          if (pass) begin
            out_row    <= row_cnt;
            out_col    <= col_cnt;
            pixel_out  <= pixel_in;
            frame_last <= last;
          end
        end
      end
      S_READ: begin
        if (rd_dx == twoh) begin
          rd_dx   <= '0;
          rd_dy   <= rd_dy + WK'(1);
          rd_slot <= (rd_slot == twoh) ? '0 : rd_slot + WK'(1);
        end else begin
          rd_dx <= rd_dx + WK'(1);
        end
      end
      S_DRAIN: begin
        drain_cnt <= drain_cnt + 3'd1;
        qd        <= '0;
      end
      S_CMP: begin
        qd <= qd + 2'd1;
        if (take) begin
          best_var <= q_var[qd];
          best_sum <= q_sum[qd];
        end
        if (qd == 2'(NUM_QUAD - 1)) begin
          rem     <= NW'({sel_sum, 1'b0}) + NW'(cnt);
          quo     <= '0;
          bit_idx <= BW'(PIXEL_BITS - 1);
        end
      end
      S_DIV: begin
        if (rem >= den_sh) begin
          rem          <= rem - den_sh;
          quo[bit_idx] <= 1'b1;
        end
        bit_idx <= bit_idx - BW'(1);
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_row    <= res_row;
          out_col    <= res_col;
          pixel_out  <= quo;
          frame_last <= res_last;
        end
      end
      default: ;
    endcase
  end

  `KUW_ASSERT(a_accept_idle, !(in_valid && in_ready) || state == S_IDLE, "transfer outside idle")
  `KUW_ASSERT_NEXT(a_start_read, xfer && !pass && interior, state == S_READ, "window read not started")
  `KUW_ASSERT(a_chain_empty, state != S_MUL || (!tag_valid && !ch_valid[NUM_QUAD]), "chain not drained")
  `KUW_ASSERT_NEXT(a_out_load, state == S_OUT && (!out_valid || out_ready), out_valid, "result lost")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kuw_pkg::*;

  typedef struct {
    logic [11:0] row;
    logic [9:0]  col;
    logic [7:0]  pix;
    logic        last;
  } px_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]            pix;
    bit                    typed;
    logic [7:0]            want;
  } stim_row_t;

  localparam int STORE_COLS = 1024;
  localparam int SETTLE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] pixel_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] out_row;
  logic [9:0] out_col;
  logic [7:0] pixel_out;
  logic frame_last;

  kuwahara_filter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .pixel_out(pixel_out),
    .frame_last(frame_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("** kuwahara_filter: FAILED **");
    $finish;
  end

  // filter model state
  logic [10:0] width_reg = 11'd640;
  logic [12:0] height_reg = 13'd480;
  logic [3:0]  window_reg = 4'd5;
  int          cur_row = 0;
  int          cur_col = 0;
  logic [7:0]  line_mem [0:15*STORE_COLS-1];
  px_result_t  pending_px[$];
  int          n_errors = 0;
  int          n_sent = 0;
  bit          no_stall = 1'b0;

  function automatic int draw_gap();
    return no_stall ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WIDTH: width_reg = val[10:0];
      CFG_HEIGHT: height_reg = val[12:0];
      CFG_WINDOW: window_reg = val[3:0];
      default: return;
    endcase
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic bit filter_pixel(logic [7:0] pix, output px_result_t res);
    int w, h, k, hw, span, side, y, x, sx, sy;
    longint cnt, s, q, v, best_v, best_s;
    logic [7:0] p;
    bit emit;
    w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
    k = window_reg;
    emit = 1'b0;
    res.last = (cur_row == h - 1 && cur_col == w - 1);
    if (k % 2 == 0) begin
      res.row = 12'(cur_row);
      res.col = 10'(cur_col);
      res.pix = pix;
      emit = 1'b1;
    end else begin
      hw = k / 2;
      span = 2 * hw + 1;
      line_mem[(cur_row % span) * STORE_COLS + (cur_col % STORE_COLS)] = pix;
      if (cur_row >= 2 * hw && cur_col >= 2 * hw) begin
        y = cur_row - hw;
        x = cur_col - hw;
        side = hw + 1;
        cnt = side * side;
        best_v = 0;
        best_s = 0;
        for (int qd = 0; qd < 4; qd++) begin
          sx = x - hw + (qd % 2) * hw;
          sy = y - hw + (qd / 2) * hw;
          s = 0;
          q = 0;
          for (int yy = sy; yy < sy + side; yy++) begin
            for (int xx = sx; xx < sx + side; xx++) begin
              p = line_mem[(yy % span) * STORE_COLS + (xx % STORE_COLS)];
              s += p;
              q += p * p;
            end
          end
          v = cnt * q - s * s;
          if (qd == 0 || v < best_v) begin
            best_v = v;
            best_s = s;
          end
        end
        res.row = 12'(y);
        res.col = 10'(x);
        res.pix = 8'((2 * best_s + cnt) / (2 * cnt));
        emit = 1'b1;
      end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
    return emit;
  endfunction

  task automatic send_pixel(logic [7:0] pix, bit typed, logic [7:0] want);
    int gap;
    px_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (filter_pixel(pix, res) || typed) begin
      if (typed) res.pix = want;
      pending_px.push_back(res);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int k);
    settle();
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_WINDOW, CFG_DATA_W'(k));
  endtask

  // result side
  int ready_wait = 0;
  always @(posedge clk) begin
    int nxt;
    px_result_t e;
    nxt = ready_wait;
    if (!rst && out_valid && out_ready) begin
      nxt = draw_gap();
      if (pending_px.size() == 0) begin
        $error("unexpected result transfer row=%0d col=%0d", out_row, out_col);
        n_errors++;
      end else begin
        e = pending_px.pop_front();
        if (out_row !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_row);
          n_errors++;
        end
        if (out_col !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_col);
          n_errors++;
        end
        if (pixel_out !== e.pix) begin
          $error("pixel_out expected %0d actual %0d", e.pix, pixel_out);
          n_errors++;
        end
        if (frame_last !== e.last) begin
          $error("frame_last expected %0d actual %0d", e.last, frame_last);
          n_errors++;
        end
      end
    end else if (nxt > 0) begin
      nxt--;
    end
    ready_wait <= nxt;
    out_ready <= (nxt == 0);
  end

  stim_row_t directed[$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    directed.push_back('{1'b1, idx, val, 8'd0, 1'b0, 8'd0});
  endfunction

  function automatic void add_pix(logic [7:0] pix, bit typed, logic [7:0] want);
    directed.push_back('{1'b0, CFG_WIDTH, '0, pix, typed, want});
  endfunction

  initial begin
    int w, h, k, frames, npix;
    // window one: every pixel comes back unchanged
    add_cfg(CFG_WIDTH, 4);
    add_cfg(CFG_HEIGHT, 1);
    add_cfg(CFG_WINDOW, 1);
    add_pix(8'h00, 1, 8'h00);
    add_pix(8'hFF, 1, 8'hFF);
    add_pix(8'h55, 1, 8'h55);
    add_pix(8'hAA, 1, 8'hAA);
    // even window: pass-through
    add_cfg(CFG_WINDOW, 2);
    add_pix(8'h0F, 1, 8'h0F);
    add_pix(8'hF0, 1, 8'hF0);
    // zero width, height and window
    add_cfg(CFG_WIDTH, 0);
    add_cfg(CFG_HEIGHT, 0);
    add_cfg(CFG_WINDOW, 0);
    add_pix(8'h81, 1, 8'h81);
    // 3x3 frame, single interior pixel
    add_cfg(CFG_WIDTH, 3);
    add_cfg(CFG_HEIGHT, 3);
    add_cfg(CFG_WINDOW, 3);
    add_pix(8'hFF, 0, 0);
    add_pix(8'h00, 0, 0);
    add_pix(8'hFF, 0, 0);
    add_pix(8'h10, 0, 0);
    add_pix(8'h80, 0, 0);
    add_pix(8'h11, 0, 0);
    add_pix(8'h00, 0, 0);
    add_pix(8'h7F, 0, 0);
    add_pix(8'h01, 0, 0);
    // window larger than the frame
    add_cfg(CFG_WINDOW, 5);
    add_pix(8'h12, 0, 0);
    add_pix(8'h34, 0, 0);
    add_pix(8'h56, 0, 0);
    add_pix(8'h78, 0, 0);
    // oversize width and height saturate, window at its largest
    add_cfg(CFG_WIDTH, 13'h7FF);
    add_cfg(CFG_HEIGHT, 13'h1FFF);
    add_cfg(CFG_WINDOW, 15);
    add_pix(8'hC3, 0, 0);
    add_pix(8'h3C, 0, 0);
    add_pix(8'h99, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_pixel(directed[i].pix, directed[i].typed, directed[i].want);
      end
    end

    // largest window on the smallest frame that has an interior pixel
    set_frame(15, 15, 15);
    for (int i = 0; i < 225; i++) send_pixel(8'($urandom_range(0, 255)), 0, 0);

    while (n_sent < 900) begin
      no_stall = ($urandom_range(0, 3) == 0);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      case ($urandom_range(0, 7))
        0: k = 2 * $urandom_range(0, 7);
        1: k = $urandom_range(1, 15);
        default: begin
          k = 1 + 2 * $urandom_range(0, 3);
          while (k > 1 && (k > w || k > h)) k -= 2;
        end
      endcase
      set_frame(w, h, k);
      frames = $urandom_range(1, 2);
      npix = frames * w * h;
      // occasional broken frame, cut short by the next register write
      if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, npix);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, 0, 0);
        else if ($urandom_range(0, 3) == 0)
          send_pixel(8'($urandom_range(120, 136)), 0, 0);
        else
          send_pixel(8'($urandom_range(0, 255)), 0, 0);
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("** kuwahara_filter: PASSED **");
    end else begin
      $display("** kuwahara_filter: FAILED **");
    end
    $finish;
  end

endmodule
